FILE: hdl/fsfl_pkg.sv
// Shared types, codes and constants for the free-list slot allocator.
package fsfl_pkg;

  localparam int NUM_ENTRIES_DEF  = 256;
  localparam int FUNC_W           = 2;
  localparam int SLOT_W           = 8;
  localparam int OFFSET_W         = 24;
  localparam int EIU_W            = 9;
  localparam int SLOT_BYTES_W     = 17;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 17;
  localparam int EIU_RESET        = 256;
  localparam int SLOT_BYTES_RESET = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENTRIES = 1'b0,
    CFG_STRIDE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_CLEAR,
    ST_RESP_ZERO,
    ST_RESP_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_EMPTY,
    RES_ALLOC
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic alloc_commit;
    logic release_commit;
    logic clear_start;
    logic clear_step;
    logic out_load;
    res_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic head_empty;
    logic clear_last;
  } stat_t;

endpackage

FILE: hdl/fsfl_ctrl.sv
// Controller state machine for the free-list slot allocator.
module fsfl_ctrl
  import fsfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  output logic              out_valid,
  input  logic              out_stall,
  input  stat_t             stat,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FUNC_ALLOC: begin
              if (!stat.head_empty) state_next = ST_ALLOC;
              else if (!out_free) state_next = ST_RESP_EMPTY;
            end
            FUNC_CLEAR: state_next = ST_CLEAR;
            FUNC_RELEASE, FUNC_NONE: begin
              if (!out_free) state_next = ST_RESP_ZERO;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_RESP_ZERO;
      end
      ST_RESP_ZERO, ST_RESP_EMPTY: begin
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_sel = RES_ZERO;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FUNC_ALLOC: begin
              if (!stat.head_empty) begin
                cmd.rd_en = 1'b1;
              end else begin
                cmd.out_load = out_free;
                cmd.out_sel  = RES_EMPTY;
              end
            end
            FUNC_RELEASE: begin
              cmd.release_commit = 1'b1;
              cmd.out_load       = out_free;
            end
            FUNC_CLEAR: begin
              cmd.clear_start = 1'b1;
            end
            FUNC_NONE: begin
              cmd.out_load = out_free;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        cmd.alloc_commit = out_free;
        cmd.out_load     = out_free;
        cmd.out_sel      = RES_ALLOC;
      end
      ST_RESP_ZERO: begin
        cmd.out_load = out_free;
      end
      ST_RESP_EMPTY: begin
        cmd.out_load = out_free;
        cmd.out_sel  = RES_EMPTY;
      end
    endcase
  end

  // A result is never written over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_load && out_valid && out_stall))
    else $error("result register loaded while a result was stalled");

  // The pop step always follows a link read issued on acceptance.
  a_alloc_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC) && !$past(state == ST_ALLOC) |-> $past(cmd.rd_en))
    else $error("allocate step entered without a link read");

  // Only one datapath update is commanded in any cycle.
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_en, cmd.alloc_commit, cmd.release_commit,
              cmd.clear_start, cmd.clear_step}))
    else $error("conflicting datapath commands");

  // A clear request always ends in a result.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) && stat.clear_last |=> (state == ST_RESP_ZERO))
    else $error("clear pass ended without a result");

endmodule

FILE: hdl/fsfl_datapath.sv
// Datapath of the free-list slot allocator: link memory, list registers, result registers.
module fsfl_datapath
  import fsfl_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [SLOT_W-1:0]      free_slot,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   status,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [OFFSET_W-1:0]    byte_offset
);

  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = (LW > EIU_W) ? LW : EIU_W;
  localparam int RW = (LW > SLOT_W) ? LW : SLOT_W;
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int OW = (IW + SLOT_BYTES_W > OFFSET_W) ? IW + SLOT_BYTES_W : OFFSET_W;
  localparam int RST_CNT = (EIU_RESET < NUM_ENTRIES) ? EIU_RESET : NUM_ENTRIES;
  localparam logic [LW-1:0] LINK_NONE = LW'(NUM_ENTRIES);

  logic [LW-1:0]           mem [NUM_ENTRIES];
  logic [LW-1:0]           rd_data;
  logic [LW-1:0]           head;
  logic [LW-1:0]           tail;
  logic [LW-1:0]           count;
  logic [IW-1:0]           cnt;
  logic [EIU_W-1:0]        entries_in_use;
  logic [SLOT_BYTES_W-1:0] slot_bytes;

  logic [IW-1:0] taken;
  logic          succ_none;
  logic [CW-1:0] eiu_ext;
  logic [CW-1:0] eiu_sat;
  logic [LW-1:0] sat;
  logic [RW-1:0] slot_ext;
  logic          slot_ok;
  logic [LW-1:0] slot_link;
  logic [IW-1:0] slot_addr;
  logic [LW-1:0] cnt_inc;
  logic [LW-1:0] clear_link;
  logic [OW-1:0] prod;
  logic [XW-1:0] taken_ext;
  logic          we;
  logic [IW-1:0] wa;
  logic [LW-1:0] wd;

  assign stat.head_empty = (head >= LINK_NONE);
  assign stat.clear_last = (cnt == IW'(NUM_ENTRIES - 1));

  assign taken     = head[IW-1:0];
  assign succ_none = (rd_data >= LINK_NONE);
  assign eiu_ext   = CW'(entries_in_use);
  assign eiu_sat   = (eiu_ext > CW'(NUM_ENTRIES)) ? CW'(NUM_ENTRIES) : eiu_ext;
  assign sat       = eiu_sat[LW-1:0];
  assign slot_ext  = RW'(free_slot);
  assign slot_ok   = (slot_ext < RW'(NUM_ENTRIES));
  assign slot_link = slot_ext[LW-1:0];
  assign slot_addr = slot_ext[IW-1:0];
  assign cnt_inc   = LW'(cnt) + LW'(1);
  // The last slot in use and every slot past it end the chain.
  assign clear_link = (cnt_inc < count) ? cnt_inc : LINK_NONE;
  assign prod      = OW'(taken) * OW'(slot_bytes);
  assign taken_ext = XW'(taken);

  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = clear_link;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.alloc_commit) begin
      we = 1'b1;
      wa = taken;
      wd = LINK_NONE;
    end else if (cmd.release_commit && slot_ok) begin
      we = 1'b1;
      wa = slot_addr;
      wd = head;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_en) rd_data <= mem[taken];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      tail           <= LW'(RST_CNT - 1);
      count          <= LW'(RST_CNT);
      cnt            <= '0;
      entries_in_use <= EIU_W'(EIU_RESET);
      slot_bytes     <= SLOT_BYTES_W'(SLOT_BYTES_RESET);
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_ENTRIES) entries_in_use <= cfg_data[EIU_W-1:0];
        if (cfg_index == CFG_STRIDE) slot_bytes <= cfg_data[SLOT_BYTES_W-1:0];
      end
      if (cmd.clear_start) begin
        count <= sat;
        cnt   <= '0;
        if (sat == '0) begin
          head <= LINK_NONE;
          tail <= LINK_NONE;
        end else begin
          head <= '0;
          tail <= sat - LW'(1);
        end
      end
      if (cmd.clear_step) cnt <= cnt + IW'(1);
      if (cmd.alloc_commit) begin
        if (succ_none) begin
          head <= LINK_NONE;
          tail <= LINK_NONE;
        end else begin
          head <= rd_data;
        end
      end
      if (cmd.release_commit && slot_ok) begin
        head <= slot_link;
        if (stat.head_empty) tail <= slot_link;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        RES_EMPTY: begin
          status      <= 1'b1;
          slot_index  <= '0;
          byte_offset <= '0;
        end
        RES_ALLOC: begin
          status      <= 1'b0;
          slot_index  <= taken_ext[SLOT_W-1:0];
          byte_offset <= prod[OFFSET_W-1:0];
        end
        default: begin
          status      <= 1'b0;
          slot_index  <= '0;
          byte_offset <= '0;
        end
      endcase
    end
  end

  // The list is empty at both ends or at neither.
  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (head >= LINK_NONE) == (tail >= LINK_NONE))
    else $error("list head and tail disagree on emptiness");

endmodule

FILE: hdl/fixed_slot_free_list_allocator.sv
// Top level of the free-list slot allocator: controller and datapath.
//
// Requests arrive on the input channel (in_valid, in_stall, func, free_slot) and each
// produces one result on the output channel (out_valid, out_stall, status,
// slot_index, byte_offset). A request is taken when valid is high and stall low.
// func selects allocate, release or clear; allocate returns the head slot and
// its byte offset (index times slot_bytes), or status 1 when the pool is empty.
// With the receiver ready, release, the unused code and allocate on an empty pool
// load the result register as the request is taken; allocate first waits on the
// registered read of the link memory, and clear first makes one link memory write
// per slot.
// The result sits in an output register; a new request is taken while it
// waits, and the block holds further work until the receiver takes it.
// After reset the block runs a relink pass over all NUM_ENTRIES slots with
// entries_in_use = 256 (saturated to NUM_ENTRIES) and takes no request meanwhile.
// Registers entries_in_use (index 0) and slot_bytes (index 1) are written through
// cfg_write, cfg_index and cfg_data; do so only while idle: the block does not check.
module fixed_slot_free_list_allocator
  import fsfl_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_W-1:0]      func,
  input  logic [SLOT_W-1:0]      free_slot,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   status,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [OFFSET_W-1:0]    byte_offset,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  fsfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fsfl_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .free_slot   (free_slot),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .slot_index  (slot_index),
    .byte_offset (byte_offset)
  );

endmodule

FILE: test/tb_fixed_slot_free_list_allocator.sv
// Self-checking testbench for the free-list slot allocator with a predictor and result queue.
module tb_fixed_slot_free_list_allocator;
  import fsfl_pkg::*;

  localparam int POOL_SLOTS = NUM_ENTRIES_DEF;
  localparam logic [EIU_W-1:0] LINK_NONE = EIU_W'(POOL_SLOTS);
  localparam int LONG_HOLD = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic                status;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
  } alloc_result_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [FUNC_W-1:0]      func;
  logic [SLOT_W-1:0]      free_slot;
  logic                   out_valid;
  logic                   out_stall;
  logic                   status;
  logic [SLOT_W-1:0]      slot_index;
  logic [OFFSET_W-1:0]    byte_offset;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predictor state: the free list as the block should hold it.
  logic [EIU_W-1:0]        link_mem [POOL_SLOTS];
  logic [EIU_W-1:0]        pool_head;
  logic [EIU_W-1:0]        pool_tail;
  logic [EIU_W-1:0]        cur_entries;
  logic [SLOT_BYTES_W-1:0] cur_stride;

  alloc_result_t     pending_results [$];
  logic [SLOT_W-1:0] held_slots [$];
  int                fail_count;
  int                idle_cycles;
  logic              steady;
  logic              long_hold_req;

  fixed_slot_free_list_allocator dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void relink_pool_model();
    int count;
    count = (cur_entries > POOL_SLOTS) ? POOL_SLOTS : int'(cur_entries);
    for (int i = 0; i < POOL_SLOTS; i++) link_mem[i] = LINK_NONE;
    if (count == 0) begin
      pool_head = LINK_NONE;
      pool_tail = LINK_NONE;
    end else begin
      for (int i = 0; i + 1 < count; i++) link_mem[i] = EIU_W'(i + 1);
      pool_head = '0;
      pool_tail = EIU_W'(count - 1);
    end
  endfunction

  function automatic alloc_result_t predict_result(func_t op, logic [SLOT_W-1:0] slot);
    alloc_result_t r;
    logic [EIU_W-1:0] taken;
    logic [EIU_W-1:0] succ;
    logic [31:0] product;
    r = '0;
    case (op)
      FUNC_ALLOC: begin
        if (pool_head >= POOL_SLOTS) begin
          r.status = 1'b1;
        end else begin
          taken = pool_head;
          succ = link_mem[taken];
          if (succ >= POOL_SLOTS) begin
            pool_head = LINK_NONE;
            pool_tail = LINK_NONE;
          end else begin
            pool_head = succ;
          end
          link_mem[taken] = LINK_NONE;
          r.slot = taken[SLOT_W-1:0];
          product = 32'(taken) * 32'(cur_stride);
          r.offset = product[OFFSET_W-1:0];
          held_slots.push_back(taken[SLOT_W-1:0]);
        end
      end
      FUNC_RELEASE: begin
        if (pool_head >= POOL_SLOTS) begin
          link_mem[slot] = LINK_NONE;
          pool_tail = EIU_W'(slot);
        end else begin
          link_mem[slot] = pool_head;
        end
        pool_head = EIU_W'(slot);
      end
      FUNC_CLEAR: begin
        relink_pool_model();
        held_slots.delete();
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checking first, then prediction for a request taken at the same edge.
  always @(posedge clk) begin : scoreboard
    alloc_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, slot_index);
            fail_count++;
          end
          if (byte_offset !== want.offset) begin
            $error("byte_offset: expected 0x%06h, got 0x%06h", want.offset, byte_offset);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_result(func_t'(func), free_slot));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("fixed_slot_free_list_allocator test failed");
        $finish;
      end
    end
  end

  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = pick_delay();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(func_t op, logic [SLOT_W-1:0] slot);
    int gap;
    gap = pick_delay();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    free_slot <= slot;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_set(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_ENTRIES) cur_entries = data[EIU_W-1:0];
    else cur_stride = data[SLOT_BYTES_W-1:0];
  endtask

  // Allocations and releases, a few unused codes and clears; releases mostly of slots known
  // to be out, some of arbitrary slots that may already be free and so link the list into a loop.
  task automatic send_random_request();
    int r;
    int pick;
    func_t op;
    logic [SLOT_W-1:0] slot;
    r = $urandom_range(0, 99);
    slot = SLOT_W'($urandom);
    op = FUNC_ALLOC;
    if (r >= 48 && r < 95) begin
      op = FUNC_RELEASE;
      if (r < 90 && held_slots.size() > 0) begin
        pick = $urandom_range(0, held_slots.size() - 1);
        slot = held_slots[pick];
        held_slots.delete(pick);
      end
    end else if (r >= 95 && r < 98) begin
      op = FUNC_NONE;
    end else if (r >= 98) begin
      op = FUNC_CLEAR;
    end
    send_request(op, slot);
  endtask

  task automatic test_reset_pool();
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'hFF);
    send_request(FUNC_NONE, 8'hA5);
    send_request(FUNC_RELEASE, 8'hFF);
    send_request(FUNC_RELEASE, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
  endtask

  task automatic test_small_pools();
    cfg_set(CFG_ENTRIES, 17'd0);
    send_request(FUNC_CLEAR, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    cfg_set(CFG_ENTRIES, 17'd1);
    send_request(FUNC_CLEAR, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    cfg_set(CFG_ENTRIES, 17'd2);
    cfg_set(CFG_STRIDE, 17'd0);
    send_request(FUNC_CLEAR, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
  endtask

  // Releasing a slot twice makes it its own successor.
  task automatic test_double_release();
    send_request(FUNC_RELEASE, 8'd5);
    send_request(FUNC_RELEASE, 8'd5);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
  endtask

  // Entry count above the pool size saturates; slot 255 is taken at stride 0x10000, slots 0 and 1 at the odd stride.
  task automatic test_stride_extremes();
    cfg_set(CFG_ENTRIES, 17'h1FF);
    cfg_set(CFG_STRIDE, 17'h10000);
    send_request(FUNC_CLEAR, 8'h00);
    send_request(FUNC_RELEASE, 8'hFF);
    send_request(FUNC_ALLOC, 8'h00);
    cfg_set(CFG_STRIDE, 17'h1FFFF);
    send_request(FUNC_ALLOC, 8'h00);
    send_request(FUNC_ALLOC, 8'h00);
  endtask

  task automatic test_random_traffic(logic [CFG_DATA_W-1:0] entries_word,
                                     logic [CFG_DATA_W-1:0] stride_word, int count);
    cfg_set(CFG_ENTRIES, entries_word);
    cfg_set(CFG_STRIDE, stride_word);
    send_request(FUNC_CLEAR, SLOT_W'($urandom));
    for (int i = 0; i < count; i++) begin
      // The sender pauses once per phase until every result is back.
      if (i == count / 3) wait_for_results();
      steady = (i >= count / 2) && (i < count / 2 + 40);
      send_random_request();
    end
    steady = 1'b0;
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    wait_for_results();
    steady = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_request();
    steady = 1'b0;
    wait_for_results();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_ALLOC;
    free_slot = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_ENTRIES;
    cfg_data = '0;
    steady = 1'b0;
    long_hold_req = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    cur_entries = EIU_W'(EIU_RESET);
    cur_stride = SLOT_BYTES_W'(SLOT_BYTES_RESET);
    relink_pool_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_pool();
    test_small_pools();
    test_double_release();
    test_stride_extremes();
    test_random_traffic(17'd256, 17'd8, 220);
    test_random_traffic(17'd3, 17'd24, 200);
    test_random_traffic(17'd17, 17'($urandom_range(1, 8192) * 8), 200);
    test_backpressure();
    test_random_traffic(17'd200, 17'h10000, 200);
    test_random_traffic({8'($urandom), 9'd300}, 17'h1FFFF, 200);
    test_random_traffic(17'($urandom_range(3, 256)), 17'($urandom_range(9, 131071) | 1), 200);

    wait_for_results();
    repeat (POOL_SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("fixed_slot_free_list_allocator test passed");
    end else begin
      $display("fixed_slot_free_list_allocator test failed");
    end
    $finish;
  end

endmodule
